[src/ial_pkg.sv]
// Shared types for the indexed array list: request actions, status codes, cell operations.
package ial_pkg;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_WRITE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // What one storage cell does at the next clock edge
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_LEFT,
    OP_RIGHT,
    OP_CLEAR
  } cell_op_t;

endpackage

[src/indexed_array_list.sv]
// Top level of the indexed array list: request decode, a chain of entry cells, result register.
// Latency: a request accepted at an edge has its result on the ports, with done high,
// in the following cycle; all cells shift in parallel at the accept edge.
// Throughput: one request per cycle; busy is high only while rst is asserted.
// Reset (synchronous, rst high): all entries zero, internal count n zero, no result strobed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module indexed_array_list #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         action,
  input  logic [4:0]         position,
  input  logic signed [31:0] value,
  output logic               busy,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] removed_value,
  output logic [4:0]         count
);
  import ial_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > 5) ? CW : 5;

  logic [CW-1:0] n;
  logic [CW-1:0] n_next;
  logic [EW-1:0] n_w;
  logic [EW-1:0] pos_w;
  logic [EW-1:0] cnt_w;
  logic          accept;
  logic          ok;
  action_t       act;
  status_t       st;
  logic [31:0]   data [CAPACITY];
  logic [31:0]   taps [CAPACITY];
  logic [31:0]   picked;
  logic [31:0]   removed_next;

  assign busy   = rst;
  assign accept = start & ~busy;
  assign act    = action_t'(action);
  assign n_w    = EW'(n);
  assign pos_w  = EW'(position);

  // Request checks against the current count
  always_comb begin
    ok = 1'b0;
    st = ST_DONE;
    case (act)
      ACT_APPEND: begin
        if (n_w >= EW'(CAPACITY)) st = ST_FULL;
        else ok = 1'b1;
      end
      ACT_INSERT: begin
        if (pos_w > n_w) st = ST_BADPOS;
        else if (n_w >= EW'(CAPACITY)) st = ST_FULL;
        else ok = 1'b1;
      end
      ACT_REMOVE: begin
        if (n_w == '0) st = ST_EMPTY;
        else if (pos_w >= n_w) st = ST_BADPOS;
        else ok = 1'b1;
      end
      ACT_WRITE: begin
        if (pos_w >= n_w) st = ST_BADPOS;
        else ok = 1'b1;
      end
      default: begin
        st = ST_BADPOS;
      end
    endcase
  end

  // Count update
  always_comb begin
    n_next = n;
    if (accept && ok) begin
      case (act)
        ACT_APPEND: n_next = n + 1'b1;
        ACT_INSERT: n_next = n + 1'b1;
        ACT_REMOVE: n_next = n - 1'b1;
        default:    n_next = n;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else begin
      n <= n_next;
    end
  end

  // Chain of entry cells, each steered by its own index compare
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [EW-1:0] IDX = EW'(i);
    cell_op_t    op;
    logic [31:0] left_value;
    logic [31:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_mid_l
      assign left_value = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_mid_r
      assign right_value = data[i+1];
    end

    always_comb begin
      op = OP_HOLD;
      if (accept && ok) begin
        case (act)
          ACT_APPEND: begin
            if (IDX == n_w) op = OP_LOAD;
          end
          ACT_INSERT: begin
            if (IDX == pos_w) op = OP_LOAD;
            else if (IDX > pos_w && IDX <= n_w) op = OP_LEFT;
          end
          ACT_REMOVE: begin
            if (IDX == n_w - 1'b1) op = OP_CLEAR;
            else if (IDX >= pos_w && (IDX + 1'b1) < n_w) op = OP_RIGHT;
          end
          ACT_WRITE: begin
            if (IDX == pos_w) op = OP_LOAD;
          end
          default: op = OP_HOLD;
        endcase
      end
    end

    // Word at the named position, zero elsewhere
    assign taps[i] = (IDX == pos_w) ? data[i] : '0;

    ial_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .load_value  (value),
      .left_value  (left_value),
      .right_value (right_value),
      .data        (data[i])
    );
  end

  // Gather the addressed word for a remove
  always_comb begin
    picked = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      picked = picked | taps[k];
    end
  end

  assign removed_next = (ok && act == ACT_REMOVE) ? picked : '0;
  assign cnt_w        = EW'(n_next);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= st;
      removed_value <= removed_next;
      count         <= cnt_w[4:0];
    end
  end

endmodule

[src/ial_cell.sv]
// One entry of the list: a 32-bit word that loads, holds, clears or takes a neighbor's word.
module ial_cell (
  input  logic              clk,
  input  logic              rst,
  input  ial_pkg::cell_op_t op,
  input  logic [31:0]       load_value,
  input  logic [31:0]       left_value,
  input  logic [31:0]       right_value,
  output logic [31:0]       data
);
  import ial_pkg::*;

  logic [31:0] data_next;

  // Select the word this cell holds after the edge
  always_comb begin
    case (op)
      OP_HOLD:  data_next = data;
      OP_LOAD:  data_next = load_value;
      OP_LEFT:  data_next = left_value;
      OP_RIGHT: data_next = right_value;
      OP_CLEAR: data_next = '0;
      default:  data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else begin
      data <= data_next;
    end
  end

endmodule
